// ----- design/binary_to_decimal_ascii_assert.svh -----
// Assertion macros for the binary-to-decimal ASCII converter checker.
// Expects clk and rst_n in scope at the point of use; no other dependencies.
`ifndef BINARY_TO_DECIMAL_ASCII_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define B2DA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("b2da check failed: same-cycle implication");

// Next-cycle implication, masked during reset.
`define B2DA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("b2da check failed: next-cycle implication");

`endif

// ----- design/b2da_pkg.sv -----
// Shared types and constants for the binary-to-decimal ASCII converter.
// No dependencies; imported by the top level and the checker.
package b2da_pkg;

  localparam int VALUE_W      = 63;
  localparam int BITS_PER_CYC = 4;
  localparam int CONV_CYC     = (VALUE_W + BITS_PER_CYC - 1) / BITS_PER_CYC;
  localparam int BIN_W        = CONV_CYC * BITS_PER_CYC;
  localparam int CYC_W        = $clog2(CONV_CYC);

  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_PERIOD = 8'h2E;

  typedef struct packed {
    logic [VALUE_W-1:0] number_value;
    logic               is_final;
  } in_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       run_end;
  } out_t;

endpackage

// ----- design/binary_to_decimal_ascii.sv -----
// Binary to decimal ASCII converter: top level, double-dabble sequencer and
// output register. Depends on b2da_pkg.
//
//   channel  | ports                     | payload
//   ---------+---------------------------+------------------------------
//   in       | in_valid/in_ready/in_data | number_value[62:0], is_final
//   out      | out_valid/out_ready/out_data | char_code[7:0], run_end
//
// One request at a time. After acceptance the shared add-3/shift unit runs
// over the whole binary value, 4 bits per cycle, then the digit register is
// walked one digit a cycle unless out stalls (leading zeros are dropped
// silently if no overflow), then one or two punctuation marks follow.
// Back-pressure on out stalls the digit walk. Reset (synchronous) returns
// the block to idle with no output pending.
module binary_to_decimal_ascii #(
  parameter int MAX_DIGITS = 19
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  b2da_pkg::in_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output b2da_pkg::out_t out_data
);
  import b2da_pkg::*;

  localparam int BCD_W  = 4 * MAX_DIGITS;
  localparam int DCNT_W = $clog2(MAX_DIGITS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_DIGIT,
    S_COMMA,
    S_LAST
  } state_t;

  state_t            state_r,   state_nxt;
  logic [BIN_W-1:0]  bin_r,     bin_nxt;
  logic [BCD_W-1:0]  bcd_r,     bcd_nxt;
  logic              ovf_r,     ovf_nxt;
  logic              final_r,   final_nxt;
  logic              started_r, started_nxt;
  logic [CYC_W-1:0]  cyc_r,     cyc_nxt;
  logic [DCNT_W-1:0] dcnt_r,    dcnt_nxt;
  logic              ovalid_r,  ovalid_nxt;
  out_t              odata_r,   odata_nxt;

  logic [BCD_W-1:0]  dab_bcd;
  logic [BIN_W-1:0]  dab_bin;
  logic              dab_ovf;
  logic [3:0]        top_dig;
  logic              can_load;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ovalid_r;
  assign out_data  = odata_r;
  assign can_load  = !ovalid_r || out_ready;
  assign top_dig   = bcd_r[BCD_W-1 -: 4];

  // Shared unit: four double-dabble steps. Anything shifted out of the top
  // digit means the value does not fit in MAX_DIGITS digits.
  always_comb begin
    dab_bcd = bcd_r;
    dab_bin = bin_r;
    dab_ovf = ovf_r;
    for (int s = 0; s < BITS_PER_CYC; s++) begin
      for (int d = 0; d < MAX_DIGITS; d++) begin
        if (dab_bcd[4*d +: 4] >= 4'd5) begin
          dab_bcd[4*d +: 4] = dab_bcd[4*d +: 4] + 4'd3;
        end
      end
      dab_ovf = dab_ovf | dab_bcd[BCD_W-1];
      dab_bcd = {dab_bcd[BCD_W-2:0], dab_bin[BIN_W-1]};
      dab_bin = dab_bin << 1;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    bin_nxt     = bin_r;
    bcd_nxt     = bcd_r;
    ovf_nxt     = ovf_r;
    final_nxt   = final_r;
    started_nxt = started_r;
    cyc_nxt     = cyc_r;
    dcnt_nxt    = dcnt_r;
    ovalid_nxt  = ovalid_r && !out_ready;
    odata_nxt   = odata_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          bin_nxt   = {{(BIN_W-VALUE_W){1'b0}}, in_data.number_value};
          bcd_nxt   = '0;
          ovf_nxt   = 1'b0;
          final_nxt = in_data.is_final;
          cyc_nxt   = '0;
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        bin_nxt = dab_bin;
        bcd_nxt = dab_bcd;
        ovf_nxt = dab_ovf;
        cyc_nxt = cyc_r + CYC_W'(1);
        if (cyc_r == CYC_W'(CONV_CYC - 1)) begin
          dcnt_nxt    = DCNT_W'(MAX_DIGITS);
          started_nxt = dab_ovf;   // overflow keeps every digit, zeros too
          state_nxt   = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (!started_r && top_dig == 4'd0 && dcnt_r > DCNT_W'(1)) begin
          bcd_nxt  = bcd_r << 4;
          dcnt_nxt = dcnt_r - DCNT_W'(1);
        end else if (can_load) begin
          ovalid_nxt          = 1'b1;
          odata_nxt.char_code = CHAR_ZERO + {4'd0, top_dig};
          odata_nxt.run_end   = 1'b0;
          bcd_nxt             = bcd_r << 4;
          started_nxt         = 1'b1;
          dcnt_nxt            = dcnt_r - DCNT_W'(1);
          if (dcnt_r == DCNT_W'(1)) begin
            state_nxt = final_r ? S_LAST : S_COMMA;
          end
        end
      end
      S_COMMA: begin
        if (can_load) begin
          ovalid_nxt          = 1'b1;
          odata_nxt.char_code = CHAR_COMMA;
          odata_nxt.run_end   = 1'b0;
          state_nxt           = S_LAST;
        end
      end
      S_LAST: begin
        if (can_load) begin
          ovalid_nxt          = 1'b1;
          odata_nxt.char_code = final_r ? CHAR_PERIOD : CHAR_SPACE;
          odata_nxt.run_end   = 1'b1;
          state_nxt           = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
    bin_r     <= bin_nxt;
    bcd_r     <= bcd_nxt;
    ovf_r     <= ovf_nxt;
    final_r   <= final_nxt;
    started_r <= started_nxt;
    cyc_r     <= cyc_nxt;
    dcnt_r    <= dcnt_nxt;
    odata_r   <= odata_nxt;
  end

endmodule

// ----- design/b2da_chk.sv -----
// Port-level checker for binary_to_decimal_ascii, bound to the top level.
// Depends on b2da_pkg and binary_to_decimal_ascii_assert.svh.
`include "binary_to_decimal_ascii_assert.svh"

module b2da_chk (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input b2da_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_ready,
  input b2da_pkg::out_t out_data
);
  import b2da_pkg::*;

  logic is_digit;
  logic in_seen;

  assign is_digit = (out_data.char_code >= CHAR_ZERO) && (out_data.char_code <= CHAR_NINE);
  assign in_seen  = in_valid && in_ready;

  // A pending character is held until taken.
  `B2DA_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
  // One request at a time: no new request straight after an acceptance.
  `B2DA_ASSERT_NXT(a_one_req, in_seen, !in_ready)
  // Only digits and the three punctuation marks are ever produced.
  `B2DA_ASSERT_IMP(a_char_set, out_valid,
      is_digit || out_data.char_code == CHAR_COMMA ||
      out_data.char_code == CHAR_SPACE || out_data.char_code == CHAR_PERIOD)
  // The run ends exactly on a space or a period.
  `B2DA_ASSERT_IMP(a_run_end, out_valid,
      out_data.run_end == (out_data.char_code == CHAR_SPACE ||
                           out_data.char_code == CHAR_PERIOD))

endmodule

bind binary_to_decimal_ascii b2da_chk u_b2da_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- tb/sv/testbench.sv -----
// Testbench for binary_to_decimal_ascii: drives numbers through the request
// channel and checks every emitted character against directed text or a
// local predictor. Depends on b2da_pkg and the binary_to_decimal_ascii RTL.
`timescale 1ns / 100ps

module testbench;
  import b2da_pkg::*;

  localparam int DIGIT_LIMIT = 19;
  localparam int RANDOM_NUMBERS = 135;
  localparam int DRAIN_CYCLES = 48;
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_DIRECTED = 15;
  localparam logic [62:0] VALUE_MAX = 63'h7FFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic [62:0] value;
    logic        fin;
    string       text;  // empty: the predictor supplies the characters
  } number_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  out_t pending_chars[$];
  int   error_count = 0;
  int   cycle_count = 0;
  int   rx_stall = 0;
  bit   no_idle = 1'b0;

  number_row_t directed_rows [N_DIRECTED] = '{
    '{63'd0, 1'b1, "0."},
    '{63'd0, 1'b0, "0, "},
    '{63'd9, 1'b0, "9, "},
    '{63'd10, 1'b1, "10."},
    '{VALUE_MAX, 1'b1, "9223372036854775807."},
    '{VALUE_MAX, 1'b0, "9223372036854775807, "},
    '{63'd1, 1'b0, ""},
    '{63'd99, 1'b1, ""},
    '{63'd100, 1'b0, ""},
    '{63'd1000000000000000000, 1'b1, "1000000000000000000."},
    '{63'd999999999999999999, 1'b0, ""},
    '{63'h2AAA_AAAA_AAAA_AAAA, 1'b0, ""},
    '{63'h5555_5555_5555_5555, 1'b1, ""},
    '{63'h4000_0000_0000_0000, 1'b0, ""},
    '{63'd12345678901234567, 1'b1, ""}
  };

  binary_to_decimal_ascii #(
    .MAX_DIGITS(DIGIT_LIMIT)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always #4 clk = ~clk;

  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic void push_char(logic [7:0] code, logic last);
    out_t ch;
    ch.char_code = code;
    ch.run_end = last;
    pending_chars.push_back(ch);
  endfunction

  // Decimal text of one number: digits MSB first, no leading zeros, then
  // the list punctuation.
  function automatic void predict_decimal(logic [62:0] value, logic fin);
    logic [63:0] rest;
    logic [3:0]  digits[$];
    int          n;
    rest = {1'b0, value};
    n = 0;
    do begin
      digits.push_front(4'(rest % 10));
      rest = rest / 10;
      n++;
    end while (rest != 0 && n < DIGIT_LIMIT);
    foreach (digits[i]) push_char(CHAR_ZERO + 8'(digits[i]), 1'b0);
    if (fin) begin
      push_char(CHAR_PERIOD, 1'b1);
    end else begin
      push_char(CHAR_COMMA, 1'b0);
      push_char(CHAR_SPACE, 1'b1);
    end
  endfunction

  function automatic void expect_text(string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i], i == s.len() - 1);
  endfunction

  task automatic send_number(logic [62:0] value, logic fin, string text);
    int gap;
    in_valid <= 1'b1;
    in_data.number_value <= value;
    in_data.is_final <= fin;
    do @(posedge clk); while (!in_ready);
    if (text.len() != 0) expect_text(text);
    else predict_decimal(value, fin);
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  // Result side back-pressure: a fresh stall length after every character.
  always @(posedge clk) begin
    int gap;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_stall <= 0;
    end else if (out_valid && out_ready) begin
      gap = draw_wait();
      rx_stall <= gap;
      out_ready <= (gap == 0) ? 1'b1 : 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall <= rx_stall - 1;
      if (rx_stall == 1) out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected character: char_code %h run_end %b",
               out_data.char_code, out_data.run_end);
        error_count++;
      end else begin
        want = pending_chars.pop_front();
        if (out_data.char_code !== want.char_code) begin
          $error("char_code: expected %h, got %h", want.char_code, out_data.char_code);
          error_count++;
        end
        if (out_data.run_end !== want.run_end) begin
          $error("run_end: expected %b, got %b", want.run_end, out_data.run_end);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    logic [63:0] raw;
    logic [62:0] value;
    logic [63:0] pow;
    int          width;
    int          k;
    rst_n <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_number(directed_rows[i].value, directed_rows[i].fin, directed_rows[i].text);

    for (int n = 0; n < RANDOM_NUMBERS; n++) begin
      no_idle = (n >= 40 && n < 70);
      if (n == 100) begin
        // hold off until every character of earlier requests is out
        in_valid <= 1'b0;
        wait_drained();
        @(posedge clk);
      end
      if ($urandom_range(0, 3) == 0) begin
        // decimal boundaries: 10^k and 10^k - 1
        k = $urandom_range(1, 18);
        pow = 64'd1;
        repeat (k) pow = pow * 64'd10;
        value = 63'(pow - $urandom_range(0, 1));
      end else begin
        raw = {$urandom, $urandom};
        width = $urandom_range(1, 63);
        value = raw[62:0] & 63'((64'd1 << width) - 1);
      end
      send_number(value, 1'($urandom_range(0, 1)), "");
    end
    no_idle = 1'b0;

    in_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
